// File: rtl/core/ple_pkg.sv
// Package for the positional list engine: operation and status codes,
// field widths and the display limit. No dependencies.
package ple_pkg;

    // Fixed widths of the request and response fields.
    localparam int unsigned OP_W     = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Largest number of values that one display request emits.
    localparam int unsigned RESULT_LIMIT = 16;

    // Operation codes; code 7 carries no operation.
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_BACK  = 3'd3,
        OP_INS_AT    = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DISPLAY   = 3'd6
    } t_op;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

endpackage

// File: rtl/core/ple_if.sv
// Request and response channel interfaces of the positional list engine.
// Depends on ple_pkg for the field widths.
interface ple_req_if;
    logic                           valid;
    logic                           ready;
    logic [ple_pkg::OP_W-1:0]       op;
    logic signed [ple_pkg::VALUE_W-1:0] value;
    logic [ple_pkg::POS_W-1:0]      position;

    modport source (output valid, op, value, position, input ready);
    modport sink   (input valid, op, value, position, output ready);
endinterface

interface ple_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ple_pkg::STATUS_W-1:0]   status;
    logic signed [ple_pkg::VALUE_W-1:0] item_value;
    logic                           has_value;
    logic [ple_pkg::COUNT_W-1:0]    entry_count;
    logic                           last;

    modport source (output valid, status, item_value, has_value, entry_count, last,
                    input ready);
    modport sink   (input valid, status, item_value, has_value, entry_count, last,
                    output ready);
endinterface

// File: rtl/core/ple_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a registered read.
// No dependencies.
module ple_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a read port whose data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer, occupancy count and response register.
// Depends on ple_pkg, ple_if (ple_req_if, ple_rsp_if) and ple_ram.

// The list lives in one RAM of CAPACITY 32-bit entries, front at address 0, and one request
// is worked at a time. An insert or delete moves every entry behind the chosen place one
// address over, one read and one write per entry through the single RAM port pair, before
// its response is loaded; a request that changes nothing goes straight to its response. A
// display reads each emitted value from the RAM and then loads it into the response
// register, and emits at most 16 values. A value or response waits while the response
// register is still held downstream. A new request is taken as soon as the previous one
// has loaded its last response, even if that response is still waiting downstream. The RAM
// needs no clearing after reset: only entries below the count are ever read.
module positional_list_engine_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_req_if.sink   i_req,
    ple_rsp_if.source o_rsp
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_WR   = 6'b000100,
        S_DRD  = 6'b001000,
        S_DDAT = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state                                r_state, n_state;
    logic [CW-1:0]                         r_occ, n_occ;
    logic [CW-1:0]                         r_ptr, n_ptr;
    logic [CW-1:0]                         r_tgt, n_tgt;
    logic                                  r_ins, n_ins;
    logic [ple_pkg::VALUE_W-1:0]           r_val, n_val;
    ple_pkg::t_status                      r_status, n_status;

    logic                                  r_out_valid, n_out_valid;
    ple_pkg::t_status                      r_out_status, n_out_status;
    logic [ple_pkg::VALUE_W-1:0]           r_out_value, n_out_value;
    logic                                  r_out_has, n_out_has;
    logic [ple_pkg::COUNT_W-1:0]           r_out_count, n_out_count;
    logic                                  r_out_last, n_out_last;

    logic                                  ram_we, ram_re;
    logic [AW-1:0]                         ram_waddr, ram_raddr;
    logic [ple_pkg::VALUE_W-1:0]           ram_wdata, ram_rdata;

    logic                                  req_acc;
    logic                                  out_free;
    logic [XW-1:0]                         pos_x, occ_x, ptr_x, lim_x;
    logic [CW-1:0]                         ptr_dn, ptr_up, pos_dn, occ_dn;
    logic [CW+ple_pkg::COUNT_W-1:0]        occ_wide;

    // Slot store.
    ple_ram #(
        .WIDTH (ple_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake helpers and widened copies for the position and limit compares.
    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign pos_x    = XW'(i_req.position);
    assign occ_x    = XW'(r_occ);
    assign ptr_x    = XW'(r_ptr);
    assign lim_x    = (occ_x > XW'(ple_pkg::RESULT_LIMIT)) ? XW'(ple_pkg::RESULT_LIMIT) : occ_x;
    assign ptr_dn   = r_ptr - CW'(1);
    assign ptr_up   = r_ptr + CW'(1);
    assign pos_dn   = CW'(pos_x - XW'(1));
    assign occ_dn   = r_occ - CW'(1);
    assign occ_wide = {{ple_pkg::COUNT_W{1'b0}}, r_occ};

    // Sequencer: decode a request, shift entries through the RAM, emit responses.
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_ptr        = r_ptr;
        n_tgt        = r_tgt;
        n_ins        = r_ins;
        n_val        = r_val;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_has    = r_out_has;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_ptr[AW-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_val    = i_req.value;
                    n_status = ple_pkg::ST_OK;
                    n_state  = S_RESP;
                    n_ptr    = r_occ;
                    unique case (i_req.op)
                        ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
                            if (occ_x >= XW'(CAPACITY)) begin
                                n_status = ple_pkg::ST_FULL;
                            end else begin
                                n_ins   = 1'b1;
                                n_tgt   = (i_req.op == ple_pkg::OP_INS_FRONT) ? '0 : r_occ;
                                n_state = S_RD;
                            end
                        end
                        ple_pkg::OP_INS_AT: begin
                            if (pos_x == '0 || pos_x > occ_x + XW'(1)) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else if (occ_x >= XW'(CAPACITY)) begin
                                n_status = ple_pkg::ST_FULL;
                            end else begin
                                n_ins   = 1'b1;
                                n_tgt   = pos_dn;
                                n_state = S_RD;
                            end
                        end
                        ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
                            if (r_occ == '0) begin
                                n_status = ple_pkg::ST_EMPTY;
                            end else begin
                                n_ins   = 1'b0;
                                n_ptr   = (i_req.op == ple_pkg::OP_DEL_FRONT) ? '0
                                                                              : occ_dn;
                                n_state = S_RD;
                            end
                        end
                        ple_pkg::OP_DEL_AT: begin
                            if (r_occ == '0) begin
                                n_status = ple_pkg::ST_EMPTY;
                            end else if (pos_x == '0 || pos_x > occ_x) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_ins   = 1'b0;
                                n_ptr   = pos_dn;
                                n_state = S_RD;
                            end
                        end
                        ple_pkg::OP_DISPLAY: begin
                            if (r_occ != '0) begin
                                n_ptr   = '0;
                                n_state = S_DRD;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // Either finish the shift or read the next entry to move.
            S_RD: begin
                if (r_ins) begin
                    if (r_ptr == r_tgt) begin
                        ram_we    = 1'b1;
                        ram_wdata = r_val;
                        n_occ     = r_occ + CW'(1);
                        n_state   = S_RESP;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_dn[AW-1:0];
                        n_state   = S_WR;
                    end
                end else begin
                    if (XW'(ptr_up) >= occ_x) begin
                        n_occ   = r_occ - CW'(1);
                        n_state = S_RESP;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_up[AW-1:0];
                        n_state   = S_WR;
                    end
                end
            end

            // Write the entry just read one place over.
            S_WR: begin
                ram_we  = 1'b1;
                n_ptr   = r_ins ? ptr_dn : ptr_up;
                n_state = S_RD;
            end

            S_DRD: begin
                ram_re  = 1'b1;
                n_state = S_DDAT;
            end

            // Emit one displayed value once the response register is free.
            S_DDAT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ple_pkg::ST_OK;
                    n_out_value  = ram_rdata;
                    n_out_has    = 1'b1;
                    n_out_count  = occ_wide[ple_pkg::COUNT_W-1:0];
                    n_out_last   = (ptr_x + XW'(1) == lim_x);
                    if (ptr_x + XW'(1) == lim_x) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = ptr_up;
                        n_state = S_DRD;
                    end
                end
            end

            // Single response of an update, an error, an unused operation code or an empty display.
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = '0;
                    n_out_has    = 1'b0;
                    n_out_count  = occ_wide[ple_pkg::COUNT_W-1:0];
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and response payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_tgt        <= n_tgt;
        r_ins        <= n_ins;
        r_val        <= n_val;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_has    <= n_out_has;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.item_value  = r_out_value;
    assign o_rsp.has_value   = r_out_has;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.last        = r_out_last;

    // The count never passes the capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_occ) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    // The RAM is written only while an insert or delete is being worked.
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_RD || r_state == S_WR))
        else $error("RAM written outside a shift");

    // An accepted request always starts work.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state != S_IDLE))
        else $error("request accepted without starting work");

    // Only displayed values carry data, and those always report success.
    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_has) |-> (r_out_status == ple_pkg::ST_OK))
        else $error("displayed value with error status");

endmodule

// File: test/ple_list_checker.sv
// Checker for the positional list engine: watches both channels, keeps its own copy
// of the list and compares every response with the one it predicts.
// Depends on ple_pkg and the channel interfaces in ple_if.
module ple_list_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ple_req_if   req_mon,
    ple_rsp_if   rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_req_total,
    output int   o_rsp_total,
    output int   o_full_seen,
    output int   o_display_values
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ple_pkg::t_status                    status;
        logic signed [ple_pkg::VALUE_W-1:0]  item_value;
        logic                                has_value;
        logic [ple_pkg::COUNT_W-1:0]         entry_count;
        logic                                last;
    } t_list_rsp;

    // Shadow copy of the list, front at index 0.
    logic signed [ple_pkg::VALUE_W-1:0] list_vals [CAPACITY];
    int                                 list_len;
    t_list_rsp                          expected_rsp [$];

    int fail_count;
    int req_total;
    int rsp_total;
    int full_seen;
    int display_values;

    function automatic void queue_result(ple_pkg::t_status st,
                                         logic signed [ple_pkg::VALUE_W-1:0] val,
                                         logic has, logic fin);
        t_list_rsp r;
        r.status      = st;
        r.item_value  = val;
        r.has_value   = has;
        r.entry_count = ple_pkg::COUNT_W'(list_len);
        r.last        = fin;
        expected_rsp.push_back(r);
    endfunction

    // Open a gap at idx and place the value there.
    function automatic void list_insert(int idx, logic signed [ple_pkg::VALUE_W-1:0] val);
        int i;
        for (i = list_len; i > idx; i--)
            list_vals[i] = list_vals[i-1];
        list_vals[idx] = val;
        list_len++;
    endfunction

    // Remove the entry at idx and close the gap behind it.
    function automatic void list_remove(int idx);
        int i;
        for (i = idx; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i+1];
        list_len--;
    endfunction

    // Work out the responses that one request causes and update the shadow list.
    function automatic void predict_request(logic [ple_pkg::OP_W-1:0] op,
                                            logic signed [ple_pkg::VALUE_W-1:0] val,
                                            logic [ple_pkg::POS_W-1:0] pos);
        ple_pkg::t_status st;
        int               n;
        int               i;
        st = ple_pkg::ST_OK;
        if (op == ple_pkg::OP_DISPLAY) begin
            n = (list_len > ple_pkg::RESULT_LIMIT) ? ple_pkg::RESULT_LIMIT : list_len;
            if (n == 0)
                queue_result(ple_pkg::ST_OK, '0, 1'b0, 1'b1);
            for (i = 0; i < n; i++)
                queue_result(ple_pkg::ST_OK, list_vals[i], 1'b1, i == n - 1);
        end else begin
            case (op)
                ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
                    if (list_len >= CAPACITY)
                        st = ple_pkg::ST_FULL;
                    else
                        list_insert((op == ple_pkg::OP_INS_FRONT) ? 0 : list_len, val);
                end
                ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
                    if (list_len == 0)
                        st = ple_pkg::ST_EMPTY;
                    else
                        list_remove((op == ple_pkg::OP_DEL_FRONT) ? 0 : list_len - 1);
                end
                ple_pkg::OP_INS_AT: begin
                    // The position test takes precedence over the full test.
                    if (pos < 1 || pos > list_len + 1)
                        st = ple_pkg::ST_BADPOS;
                    else if (list_len >= CAPACITY)
                        st = ple_pkg::ST_FULL;
                    else
                        list_insert(pos - 1, val);
                end
                ple_pkg::OP_DEL_AT: begin
                    if (list_len == 0)
                        st = ple_pkg::ST_EMPTY;
                    else if (pos < 1 || pos > list_len)
                        st = ple_pkg::ST_BADPOS;
                    else
                        list_remove(pos - 1);
                end
                default: begin
                end
            endcase
            queue_result(st, '0, 1'b0, 1'b1);
        end
    endfunction

    // Predict on each accepted request, then check each accepted response.
    always @(posedge i_clk) begin
        t_list_rsp seen;
        t_list_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_rsp.delete();
            fail_count     = 0;
            req_total      = 0;
            rsp_total      = 0;
            full_seen      = 0;
            display_values = 0;
        end else begin
            if (req_mon.valid && req_mon.ready) begin
                req_total++;
                predict_request(req_mon.op, req_mon.value, req_mon.position);
            end
            if (rsp_mon.valid && rsp_mon.ready) begin
                rsp_total++;
                seen.status      = ple_pkg::t_status'(rsp_mon.status);
                seen.item_value  = rsp_mon.item_value;
                seen.has_value   = rsp_mon.has_value;
                seen.entry_count = rsp_mon.entry_count;
                seen.last        = rsp_mon.last;
                if (seen.status == ple_pkg::ST_FULL)
                    full_seen++;
                if (seen.has_value === 1'b1)
                    display_values++;
                if (expected_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected response: status %0d value %0h",
                                 $realtime, seen.status, seen.item_value);
                end else begin
                    want = expected_rsp.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: response %0d differs", $realtime, rsp_total);
                            $display("  expected st %0d val %0h has %0b cnt %0d last %0b",
                                     want.status, want.item_value, want.has_value,
                                     want.entry_count, want.last);
                            $display("  actual   st %0d val %0h has %0b cnt %0d last %0b",
                                     seen.status, seen.item_value, seen.has_value,
                                     seen.entry_count, seen.last);
                        end
                    end
                end
            end
        end
        o_fail_count     <= fail_count;
        o_pending        <= expected_rsp.size();
        o_req_total      <= req_total;
        o_rsp_total      <= rsp_total;
        o_full_seen      <= full_seen;
        o_display_values <= display_values;
    end

endmodule

// File: test/tb.sv
// Top of the positional list engine testbench: clock, reset, request stimulus and
// response back-pressure, and the final verdict.
// Depends on ple_pkg, ple_if, positional_list_engine_core and ple_list_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam logic signed [ple_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ple_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int req_total;
    int rsp_total;
    int full_seen;
    int display_values;
    int drain_errors;
    int list_len;
    bit stalls_on;

    positional_list_engine_core #(.CAPACITY(CAPACITY)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ple_list_checker #(.CAPACITY(CAPACITY)) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .req_mon          (req_ch),
        .rsp_mon          (rsp_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_req_total      (req_total),
        .o_rsp_total      (rsp_total),
        .o_full_seen      (full_seen),
        .o_display_values (display_values)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Response back-pressure: random stall bursts while enabled.
    initial begin
        rsp_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Entry count after a request, used only to aim positions at the live list.
    function automatic int count_after(logic [ple_pkg::OP_W-1:0] op,
                                       logic [ple_pkg::POS_W-1:0] pos, int n);
        case (op)
            ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: return (n < CAPACITY) ? n + 1 : n;
            ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: return (n > 0) ? n - 1 : n;
            ple_pkg::OP_INS_AT:
                return (pos >= 1 && pos <= n + 1 && n < CAPACITY) ? n + 1 : n;
            ple_pkg::OP_DEL_AT: return (pos >= 1 && pos <= n) ? n - 1 : n;
            default:            return n;
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [ple_pkg::OP_W-1:0] op,
                                input logic signed [ple_pkg::VALUE_W-1:0] val,
                                input logic [ple_pkg::POS_W-1:0] pos);
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.value    <= val;
        req_ch.position <= pos;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        list_len = count_after(op, pos, list_len);
    endtask

    task automatic hold_off(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending until every predicted response has come back.
    task automatic wait_drained();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending != 0)
            drain_errors++;
        @(posedge i_clk);
    endtask

    // One random request; ins_weight is the share of list updates that insert.
    task automatic random_request(input int ins_weight, input bit idle_on);
        int r;
        logic [ple_pkg::OP_W-1:0] op;
        logic [ple_pkg::POS_W-1:0] pos;
        logic signed [ple_pkg::VALUE_W-1:0] val;
        r = $urandom_range(0, 99);
        if (r < 8)
            op = ple_pkg::OP_DISPLAY;
        else if (r < 10)
            op = OP_UNUSED;
        else if ($urandom_range(0, 99) < ins_weight)
            case ($urandom_range(0, 2))
                0:       op = ple_pkg::OP_INS_FRONT;
                1:       op = ple_pkg::OP_INS_BACK;
                default: op = ple_pkg::OP_INS_AT;
            endcase
        else
            case ($urandom_range(0, 2))
                0:       op = ple_pkg::OP_DEL_FRONT;
                1:       op = ple_pkg::OP_DEL_BACK;
                default: op = ple_pkg::OP_DEL_AT;
            endcase

        // Mostly legal positions, with some zero and some anywhere in range.
        r = $urandom_range(0, 9);
        if (op != ple_pkg::OP_INS_AT && op != ple_pkg::OP_DEL_AT)
            pos = $urandom_range(0, 255);
        else if (r == 0)
            pos = '0;
        else if (r == 1)
            pos = $urandom_range(0, 255);
        else if (op == ple_pkg::OP_INS_AT)
            pos = $urandom_range(1, list_len + 1);
        else
            pos = $urandom_range(1, (list_len > 0) ? list_len : 1);

        case ($urandom_range(0, 15))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase

        if (idle_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 9));
        send_request(op, val, pos);
    endtask

    initial begin
        int phase;
        int k;
        drain_errors = 0;
        list_len     = 0;
        stalls_on    = 1'b0;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= ple_pkg::OP_DISPLAY;
        req_ch.value    <= '0;
        req_ch.position <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list cases, bad positions, extreme values, middle updates.
        send_request(ple_pkg::OP_DISPLAY,   '0,      8'd0);
        send_request(ple_pkg::OP_DEL_FRONT, '0,      8'd0);
        send_request(ple_pkg::OP_DEL_BACK,  '0,      8'd0);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd0);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd1);
        send_request(ple_pkg::OP_INS_AT,    VAL_MAX, 8'd0);
        send_request(ple_pkg::OP_INS_AT,    VAL_MAX, 8'd2);
        send_request(ple_pkg::OP_INS_AT,    VAL_MAX, 8'd1);
        send_request(ple_pkg::OP_INS_FRONT, VAL_MIN, 8'd0);
        send_request(ple_pkg::OP_INS_BACK,  '0,      8'd0);
        send_request(ple_pkg::OP_INS_BACK,  '1,      8'd0);
        send_request(ple_pkg::OP_INS_AT,    32'sh5555_aaaa, 8'd5);
        send_request(ple_pkg::OP_INS_AT,    32'sh1234_5678, 8'd3);
        send_request(ple_pkg::OP_DISPLAY,   '0,      8'd0);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd0);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd7);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd255);
        send_request(ple_pkg::OP_INS_AT,    VAL_MIN, 8'd255);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd2);
        send_request(ple_pkg::OP_DEL_AT,    '0,      8'd5);
        send_request(OP_UNUSED,             '1,      8'haa);
        send_request(ple_pkg::OP_DISPLAY,   '0,      8'd0);

        // Let everything drain before the random part starts.
        wait_drained();

        // Random phases: fill towards full, drain towards empty, mixed, fill again, then mixed without stalls.
        stalls_on = 1'b1;
        for (phase = 0; phase < 5; phase++) begin
            if (phase == 4)
                stalls_on = 1'b0;
            for (k = 0; k < 50; k++)
                case (phase)
                    0, 3:    random_request(80, 1'b1);
                    1:       random_request(20, 1'b1);
                    2:       random_request(50, 1'b1);
                    default: random_request(55, 1'b0);
                endcase
            if (phase < 3)
                wait_drained();
        end

        wait_drained();
        hold_off(60);

        $display("Run covered %0d requests and %0d responses.", req_total, rsp_total);
        $display("Listed %0d values and saw %0d full rejections.", display_values, full_seen);
        if (fail_count == 0 && drain_errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
